[src/arp_cache_responder_resolver_unit_macros.svh]
// Assertion macros shared by the checker files of the ARP cache unit.
// Needs signals named clock and reset in the scope of each use.
`ifndef ARP_CACHE_RESPONDER_RESOLVER_UNIT_MACROS_SVH
`define ARP_CACHE_RESPONDER_RESOLVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARPC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/arpc_pkg.sv]
// Shared constants, codes, types and the retry interval function of the ARP cache unit.
// No dependencies; imported by every other file except the macros header.
package arpc_pkg;

   localparam int CACHE_ENTRIES   = 256;
   localparam int PENDING_ENTRIES = 8;
   localparam int MAX_RETRIES     = 5;

   localparam int CIDX_W    = $clog2(CACHE_ENTRIES);
   localparam int PIDX_W    = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
   localparam int IP_W      = 32;
   localparam int MAC_W     = 48;
   localparam int OP_W      = 16;
   localparam int TYPE_W    = 2;
   localparam int KIND_W    = 3;
   localparam int BASE_W    = 16;
   localparam int TRIES_W   = 3;
   localparam int CD_W      = 22;
   localparam int SHV_W     = BASE_W + (1 << TRIES_W) - 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 48;
   localparam int ENTRY_W   = IP_W + MAC_W;

   localparam logic [CD_W-1:0]    CD_MAX    = '1;
   localparam logic [TRIES_W-1:0] TRIES_MAX = TRIES_W'(MAX_RETRIES);

   localparam logic [TYPE_W-1:0] REQ_PACKET = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TICK   = 2'd2;

   localparam logic [OP_W-1:0] ARP_OP_REQUEST = 16'd1;

   localparam logic [KIND_W-1:0] KIND_REPLY    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BCAST    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HIT      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESOLVED = 3'd4;
   localparam logic [KIND_W-1:0] KIND_GAVEUP   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_MAC     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_INTERVAL = 2'd2;

   localparam logic [BASE_W-1:0] BASE_INTERVAL_RESET = 16'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEARN_SCAN,
      ST_QUERY_SCAN,
      ST_PEND_SCAN,
      ST_PEND_DECIDE,
      ST_TICK,
      ST_TICK_SCAN,
      ST_TICK_NEXT,
      ST_EMIT
   } arpc_state_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [OP_W-1:0]   opcode;
      logic [IP_W-1:0]   sender_ip;
      logic [MAC_W-1:0]  sender_mac;
      logic [IP_W-1:0]   target_ip;
   } arpc_item_type;

   typedef struct packed {
      logic [IP_W-1:0]   local_ip;
      logic [MAC_W-1:0]  local_mac;
      logic [BASE_W-1:0] base_interval_ticks;
   } arpc_cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic              last;
   } arpc_result_type;

   typedef struct packed {
      logic              en;
      logic [CIDX_W-1:0] idx;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
   } arpc_cache_wr_type;

   typedef struct packed {
      logic              done;
      logic              hit;
      logic [CIDX_W-1:0] hit_idx;
      logic [MAC_W-1:0]  hit_mac;
      logic              free_ok;
      logic [CIDX_W-1:0] free_idx;
   } arpc_scan_type;

   function automatic logic [CD_W-1:0] arpc_interval(input logic [BASE_W-1:0] base,
                                                     input logic [TRIES_W-1:0] tries);
      logic [BASE_W-1:0] b;
      logic [SHV_W-1:0]  v;
      b = (base == '0) ? BASE_W'(1) : base;
      v = SHV_W'(b) << tries;
      if (v > SHV_W'(CD_MAX)) begin
         return CD_MAX;
      end
      return v[CD_W-1:0];
   endfunction

endpackage

[src/arpc_req_if.sv]
// Request channel of the ARP cache unit: valid, ready and the request fields.
// Depends on arpc_pkg for field widths.
interface arpc_req_if import arpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [OP_W-1:0]   opcode;
   logic [IP_W-1:0]   sender_ip;
   logic [MAC_W-1:0]  sender_mac;
   logic [IP_W-1:0]   target_ip;

   modport source (output valid, output req_type, output opcode, output sender_ip,
                   output sender_mac, output target_ip, input ready);
   modport sink   (input valid, input req_type, input opcode, input sender_ip,
                   input sender_mac, input target_ip, output ready);
endinterface

[src/arpc_rsp_if.sv]
// Response channel of the ARP cache unit: valid, ready and the result fields.
// Depends on arpc_pkg for field widths.
interface arpc_rsp_if import arpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] out_kind;
   logic [IP_W-1:0]   out_ip;
   logic [MAC_W-1:0]  out_mac;
   logic              last;

   modport source (output valid, output out_kind, output out_ip, output out_mac,
                   output last, input ready);
   modport sink   (input valid, input out_kind, input out_ip, input out_mac,
                   input last, output ready);
endinterface

[src/arpc_cache.sv]
// Cache store with valid bits and the shared sweep comparator, one entry per cycle.
// Depends on arpc_pkg.
module arpc_cache import arpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              scan_start,
   input  logic [IP_W-1:0]   scan_key,
   input  arpc_cache_wr_type cache_wr,
   output arpc_scan_type     scan
);

   logic [ENTRY_W-1:0] mem [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] valid_ff;

   logic              issue_ff, issue_in;
   logic [CIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic              cmp_ff;
   logic [CIDX_W-1:0] cmp_idx_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic              done_ff, done_in;
   logic [IP_W-1:0]   key_ff, key_in;
   logic              hit_ff, hit_in;
   logic [CIDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [MAC_W-1:0]  hit_mac_ff, hit_mac_in;
   logic              free_ok_ff, free_ok_in;
   logic [CIDX_W-1:0] free_idx_ff, free_idx_in;
   logic              key_eq;

   localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(CACHE_ENTRIES - 1);

   always_ff @(posedge clock) begin
      if (cache_wr.en) begin
         mem[cache_wr.idx] <= {cache_wr.ip, cache_wr.mac};
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cache_wr.en) begin
         valid_ff[cache_wr.idx] <= 1'b1;
      end
   end

   assign key_eq = (rd_data_ff[ENTRY_W-1:MAC_W] == key_ff);

   always_comb begin
      issue_in    = issue_ff;
      rd_idx_in   = rd_idx_ff;
      key_in      = key_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_mac_in  = hit_mac_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      done_in     = cmp_ff && (cmp_idx_ff == LAST_IDX);
      if (scan_start) begin
         issue_in   = 1'b1;
         rd_idx_in  = '0;
         key_in     = scan_key;
         hit_in     = 1'b0;
         free_ok_in = 1'b0;
      end else if (issue_ff) begin
         rd_idx_in = rd_idx_ff + CIDX_W'(1);
         if (rd_idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end
      if (cmp_ff) begin
         if (rd_vld_ff && key_eq && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_mac_in = rd_data_ff[MAC_W-1:0];
         end
         if (!rd_vld_ff && !free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         cmp_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         cmp_ff   <= issue_ff && !scan_start;
         done_ff  <= done_in;
      end
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= rd_idx_ff;
      rd_vld_ff   <= valid_ff[rd_idx_ff];
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_mac_ff  <= hit_mac_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
   end

   assign scan.done     = done_ff;
   assign scan.hit      = hit_ff;
   assign scan.hit_idx  = hit_idx_ff;
   assign scan.hit_mac  = hit_mac_ff;
   assign scan.free_ok  = free_ok_ff;
   assign scan.free_idx = free_idx_ff;

endmodule

[src/arpc_seq.sv]
// Sequencer of the ARP cache unit: pending table, retry timers and result building.
// Depends on arpc_pkg; drives the cache sweep in arpc_cache.
module arpc_seq import arpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arpc_item_type     item,
   input  arpc_cfg_type      cfg,
   input  arpc_scan_type     scan,
   output logic              scan_start,
   output logic [IP_W-1:0]   scan_key,
   output arpc_cache_wr_type cache_wr,
   input  logic              out_free,
   output logic              push,
   output arpc_result_type   res
);

   arpc_state_type state_ff, state_in;

   logic [TYPE_W-1:0] type_ff, type_in;
   logic [OP_W-1:0]   opcode_ff, opcode_in;
   logic [IP_W-1:0]   sip_ff, sip_in;
   logic [MAC_W-1:0]  smac_ff, smac_in;
   logic [IP_W-1:0]   tip_ff, tip_in;
   logic [PIDX_W-1:0] pidx_ff, pidx_in;
   logic              found_ff, found_in;
   logic              free_ok_ff, free_ok_in;
   logic [PIDX_W-1:0] free_idx_ff, free_idx_in;
   arpc_result_type   res_ff, res_in;

   logic               pend_valid_ff [PENDING_ENTRIES];
   logic               pend_valid_in [PENDING_ENTRIES];
   logic [IP_W-1:0]    pend_addr_ff  [PENDING_ENTRIES];
   logic [IP_W-1:0]    pend_addr_in  [PENDING_ENTRIES];
   logic [TRIES_W-1:0] pend_tries_ff [PENDING_ENTRIES];
   logic [TRIES_W-1:0] pend_tries_in [PENDING_ENTRIES];
   logic [CD_W-1:0]    pend_cd_ff    [PENDING_ENTRIES];
   logic [CD_W-1:0]    pend_cd_in    [PENDING_ENTRIES];

   logic [IP_W-1:0]    cmp_a, cmp_b;
   logic               cmp_eq;
   logic               cur_exp, later_exp, pidx_last;
   logic [TRIES_W-1:0] tries_next;

   localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PENDING_ENTRIES - 1);

   always_comb begin
      if (state_ff == ST_IDLE) begin
         cmp_a = item.target_ip;
         cmp_b = cfg.local_ip;
      end else begin
         cmp_a = tip_ff;
         cmp_b = pend_addr_ff[pidx_ff];
      end
   end

   assign cmp_eq     = (cmp_a == cmp_b);
   assign cur_exp    = pend_valid_ff[pidx_ff] && (pend_cd_ff[pidx_ff] <= CD_W'(1));
   assign pidx_last  = (pidx_ff == PIDX_LAST);
   assign tries_next = pend_tries_ff[pidx_ff] + TRIES_W'(1);

   always_comb begin
      later_exp = 1'b0;
      for (int j = 0; j < PENDING_ENTRIES; j++) begin
         if ((PIDX_W'(j) > pidx_ff) && pend_valid_ff[j] && (pend_cd_ff[j] <= CD_W'(1))) begin
            later_exp = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (item.req_type)
                  REQ_PACKET: state_in = cmp_eq ? ST_LEARN_SCAN : ST_IDLE;
                  REQ_QUERY:  state_in = ST_QUERY_SCAN;
                  REQ_TICK:   state_in = ST_TICK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LEARN_SCAN: begin
            if (scan.done) begin
               state_in = (opcode_ff == ARP_OP_REQUEST) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_QUERY_SCAN: begin
            if (scan.done) begin
               state_in = scan.hit ? ST_EMIT : ST_PEND_SCAN;
            end
         end
         ST_PEND_SCAN: begin
            if (pidx_last) begin
               state_in = ST_PEND_DECIDE;
            end
         end
         ST_PEND_DECIDE: state_in = ST_EMIT;
         ST_TICK: begin
            if (cur_exp) begin
               state_in = ST_TICK_SCAN;
            end else if (pidx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_SCAN: begin
            if (scan.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_TICK_NEXT: state_in = pidx_last ? ST_IDLE : ST_TICK;
         ST_EMIT: begin
            if (out_free) begin
               state_in = (type_ff == REQ_TICK) ? ST_TICK_NEXT : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      type_in       = type_ff;
      opcode_in     = opcode_ff;
      sip_in        = sip_ff;
      smac_in       = smac_ff;
      tip_in        = tip_ff;
      pidx_in       = pidx_ff;
      found_in      = found_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      res_in        = res_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_tries_in = pend_tries_ff;
      pend_cd_in    = pend_cd_ff;
      req_ready     = (state_ff == ST_IDLE);
      scan_start    = 1'b0;
      scan_key      = item.sender_ip;
      cache_wr      = '0;
      push          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in   = item.req_type;
               opcode_in = item.opcode;
               sip_in    = item.sender_ip;
               smac_in   = item.sender_mac;
               tip_in    = item.target_ip;
               pidx_in   = '0;
               case (item.req_type)
                  REQ_PACKET: begin
                     scan_start = cmp_eq;
                     scan_key   = item.sender_ip;
                  end
                  REQ_QUERY: begin
                     scan_start = 1'b1;
                     scan_key   = item.target_ip;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LEARN_SCAN: begin
            if (scan.done) begin
               cache_wr.en  = scan.hit || scan.free_ok;
               cache_wr.idx = scan.hit ? scan.hit_idx : scan.free_idx;
               cache_wr.ip  = sip_ff;
               cache_wr.mac = smac_ff;
               res_in = '{kind: KIND_REPLY, ip: sip_ff, mac: smac_ff, last: 1'b1};
            end
         end
         ST_QUERY_SCAN: begin
            if (scan.done) begin
               res_in     = '{kind: KIND_HIT, ip: tip_ff, mac: scan.hit_mac, last: 1'b1};
               pidx_in    = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
            end
         end
         ST_PEND_SCAN: begin
            if (pend_valid_ff[pidx_ff] && cmp_eq) begin
               found_in = 1'b1;
            end else if (!pend_valid_ff[pidx_ff] && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = pidx_ff;
            end
            if (!pidx_last) begin
               pidx_in = pidx_ff + PIDX_W'(1);
            end
         end
         ST_PEND_DECIDE: begin
            if (found_ff) begin
               res_in = '{kind: KIND_QUEUED, ip: tip_ff, mac: '0, last: 1'b1};
            end else if (free_ok_ff) begin
               pend_valid_in[free_idx_ff] = 1'b1;
               pend_addr_in[free_idx_ff]  = tip_ff;
               pend_tries_in[free_idx_ff] = '0;
               pend_cd_in[free_idx_ff]    = arpc_interval(cfg.base_interval_ticks, '0);
               res_in = '{kind: KIND_BCAST, ip: tip_ff, mac: '0, last: 1'b1};
            end else begin
               res_in = '{kind: KIND_DROPPED, ip: tip_ff, mac: '0, last: 1'b1};
            end
         end
         ST_TICK: begin
            if (cur_exp) begin
               scan_start = 1'b1;
               scan_key   = pend_addr_ff[pidx_ff];
            end else begin
               if (pend_valid_ff[pidx_ff]) begin
                  pend_cd_in[pidx_ff] = pend_cd_ff[pidx_ff] - CD_W'(1);
               end
               if (!pidx_last) begin
                  pidx_in = pidx_ff + PIDX_W'(1);
               end
            end
         end
         ST_TICK_SCAN: begin
            if (scan.done) begin
               if (scan.hit) begin
                  pend_valid_in[pidx_ff] = 1'b0;
                  res_in = '{kind: KIND_RESOLVED, ip: pend_addr_ff[pidx_ff],
                             mac: scan.hit_mac, last: !later_exp};
               end else if (pend_tries_ff[pidx_ff] >= TRIES_MAX) begin
                  pend_valid_in[pidx_ff] = 1'b0;
                  res_in = '{kind: KIND_GAVEUP, ip: pend_addr_ff[pidx_ff],
                             mac: '0, last: !later_exp};
               end else begin
                  pend_tries_in[pidx_ff] = tries_next;
                  pend_cd_in[pidx_ff]    = arpc_interval(cfg.base_interval_ticks, tries_next);
                  res_in = '{kind: KIND_BCAST, ip: pend_addr_ff[pidx_ff],
                             mac: '0, last: !later_exp};
               end
            end
         end
         ST_TICK_NEXT: begin
            if (!pidx_last) begin
               pidx_in = pidx_ff + PIDX_W'(1);
            end
         end
         ST_EMIT: push = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < PENDING_ENTRIES; i++) begin
            pend_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
      type_ff       <= type_in;
      opcode_ff     <= opcode_in;
      sip_ff        <= sip_in;
      smac_ff       <= smac_in;
      tip_ff        <= tip_in;
      pidx_ff       <= pidx_in;
      found_ff      <= found_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      res_ff        <= res_in;
      pend_addr_ff  <= pend_addr_in;
      pend_tries_ff <= pend_tries_in;
      pend_cd_ff    <= pend_cd_in;
   end

   assign res = res_ff;

endmodule

[src/arp_cache_responder_resolver_unit.sv]
// Top level of the ARP cache unit: configuration registers, response register, wiring.
// Depends on arpc_pkg, arpc_req_if, arpc_rsp_if, arpc_cache and arpc_seq.
//
// Usage: requests enter on req (valid/ready): a received ARP packet, a resolve
// query or a timer tick. Results leave on rsp (valid/ready), one per beat, with
// last set on the final result of a request. csr_wr_en writes the register at
// csr_index (local IP, local MAC, base retry interval) from csr_wdata; write
// only while no request is in flight.
// Each cache lookup sweeps all 256 entries through one comparator at one entry
// per cycle; a query miss adds a pass over the 8-entry pending table and a
// decision step. A tick visits each pending entry in turn and runs a cache
// sweep for each expiring entry. req.ready is high only while the sequencer is
// idle; one request is in work at a time.
// Reset clears the cache and pending valid bits at once (no clearing pass) and
// loads the register defaults. A stalled receiver holds the result in the
// response register; the sequencer waits only when it has a further result.
module arp_cache_responder_resolver_unit import arpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   arpc_req_if.sink             req,
   arpc_rsp_if.source           rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   arpc_cfg_type      cfg_ff, cfg_in;
   arpc_item_type     item;
   arpc_scan_type     scan;
   arpc_cache_wr_type cache_wr;
   arpc_result_type   res, rsp_res_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              scan_start;
   logic [IP_W-1:0]   scan_key;
   logic              push, out_free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOCAL_IP:      cfg_in.local_ip            = csr_wdata[IP_W-1:0];
            CSR_LOCAL_MAC:     cfg_in.local_mac           = csr_wdata[MAC_W-1:0];
            CSR_BASE_INTERVAL: cfg_in.base_interval_ticks = csr_wdata[BASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign item.req_type   = req.req_type;
   assign item.opcode     = req.opcode;
   assign item.sender_ip  = req.sender_ip;
   assign item.sender_mac = req.sender_mac;
   assign item.target_ip  = req.target_ip;

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = push || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_ip            <= '0;
         cfg_ff.local_mac           <= '0;
         cfg_ff.base_interval_ticks <= BASE_INTERVAL_RESET;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (push) begin
         rsp_res_ff <= res;
      end
   end

   arpc_cache u_cache (
      .clock      (clock),
      .reset      (reset),
      .scan_start (scan_start),
      .scan_key   (scan_key),
      .cache_wr   (cache_wr),
      .scan       (scan)
   );

   arpc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .item       (item),
      .cfg        (cfg_ff),
      .scan       (scan),
      .scan_start (scan_start),
      .scan_key   (scan_key),
      .cache_wr   (cache_wr),
      .out_free   (out_free),
      .push       (push),
      .res        (res)
   );

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_kind = rsp_res_ff.kind;
   assign rsp.out_ip   = rsp_res_ff.ip;
   assign rsp.out_mac  = rsp_res_ff.mac;
   assign rsp.last     = rsp_res_ff.last;

endmodule

[src/arpc_checker.sv]
// Port-level checks of the ARP cache unit and the bind that attaches them.
// Depends on arpc_pkg and arp_cache_responder_resolver_unit_macros.svh.
`include "arp_cache_responder_resolver_unit_macros.svh"

module arpc_checker import arpc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_out_kind,
   input logic [IP_W-1:0]   rsp_out_ip,
   input logic [MAC_W-1:0]  rsp_out_mac,
   input logic              rsp_last
);

   `ARPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `ARPC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_out_kind) && $stable(rsp_out_ip) && $stable(rsp_out_mac) && $stable(rsp_last), "stalled response changed")
   `ARPC_ASSERT_IMP(a_single_last, rsp_valid && (rsp_out_kind == KIND_REPLY || rsp_out_kind == KIND_HIT || rsp_out_kind == KIND_QUEUED || rsp_out_kind == KIND_DROPPED), rsp_last, "single-result kind without last")
   `ARPC_ASSERT_IMP(a_busy_mid_tick, rsp_valid && !rsp_last && req_valid, !req_ready, "request taken before final result")
   `ARPC_ASSERT_IMP(a_mac_zero, rsp_valid && (rsp_out_kind == KIND_BCAST || rsp_out_kind == KIND_QUEUED || rsp_out_kind == KIND_GAVEUP || rsp_out_kind == KIND_DROPPED), rsp_out_mac == '0, "nonzero MAC on address-only result")

endmodule

bind arp_cache_responder_resolver_unit arpc_checker u_arpc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_kind (rsp.out_kind),
   .rsp_out_ip   (rsp.out_ip),
   .rsp_out_mac  (rsp.out_mac),
   .rsp_last     (rsp.last)
);

[dv/arp_cache_responder_resolver_unit_tb.sv]
// Self-checking testbench for the ARP cache unit: directed and random requests against
// a cycle-free model of the cache, pending table and retry timer.
// Depends on arpc_pkg, arpc_req_if, arpc_rsp_if and the unit itself.
module arp_cache_responder_resolver_unit_tb;
   import arpc_pkg::*;

   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 1000;
   localparam int POOL_SIZE     = 40;

   localparam logic [TYPE_W-1:0] REQ_UNUSED   = 2'd3;
   localparam logic [OP_W-1:0]   ARP_OP_REPLY = 16'd2;

   typedef enum int {TRAFFIC_MIXED, TRAFFIC_TICKS, TRAFFIC_FILL} traffic_type;

   typedef struct {
      arpc_item_type item;
      int            gap;
      bit            hold;
   } pending_request_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   arpc_req_if req_ch ();
   arpc_rsp_if rsp_ch ();

   arp_cache_responder_resolver_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state
   logic [IP_W-1:0]    cfg_ip;
   logic [MAC_W-1:0]   cfg_mac;
   logic [BASE_W-1:0]  cfg_base;
   logic               cache_used [CACHE_ENTRIES];
   logic [IP_W-1:0]    cache_ip   [CACHE_ENTRIES];
   logic [MAC_W-1:0]   cache_mac  [CACHE_ENTRIES];
   logic               pend_used  [PENDING_ENTRIES];
   logic [IP_W-1:0]    pend_ip    [PENDING_ENTRIES];
   logic [TRIES_W-1:0] pend_try   [PENDING_ENTRIES];
   logic [CD_W-1:0]    pend_left  [PENDING_ENTRIES];

   arpc_result_type     arp_results_due [$];
   arpc_result_type     step_results [$];
   pending_request_type requests_to_send [$];
   pending_request_type in_flight;

   arpc_result_type observed;
   arpc_result_type wanted;
   int  requests_issued   = 0;
   int  requests_accepted = 0;
   int  results_checked   = 0;
   int  error_count       = 0;
   int  quiet_cycles      = 0;
   int  rsp_wait          = 0;
   int  rsp_draw;
   int  fill_serial       = 0;
   int  kind_tally [8];
   bit  calm              = 1'b0;

   always #4 clock = ~clock;

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 11);
   endfunction

   function automatic int cache_slot(input logic [IP_W-1:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++)
         if (cache_used[i] && cache_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic void cache_store(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
      int slot;
      slot = cache_slot(ip);
      if (slot < 0) begin
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!cache_used[i] && slot < 0) slot = i;
      end
      if (slot >= 0) begin
         cache_used[slot] = 1'b1;
         cache_ip[slot]   = ip;
         cache_mac[slot]  = mac;
      end
   endfunction

   function automatic logic [CD_W-1:0] retry_ticks(input logic [TRIES_W-1:0] tries);
      longint unsigned span;
      span = (cfg_base == '0) ? 1 : cfg_base;
      span = span << tries;
      return (span > CD_MAX) ? CD_MAX : span[CD_W-1:0];
   endfunction

   function automatic void add_result(input logic [KIND_W-1:0] kind, input logic [IP_W-1:0] ip,
                                      input logic [MAC_W-1:0] mac);
      arpc_result_type r;
      r.kind = kind;
      r.ip   = ip;
      r.mac  = mac;
      r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void arp_engine_predict(input arpc_item_type it);
      int  slot;
      int  free_slot;
      bit  waiting;
      step_results.delete();
      case (it.req_type)
         REQ_PACKET: begin
            if (it.target_ip == cfg_ip) begin
               cache_store(it.sender_ip, it.sender_mac);
               if (it.opcode == ARP_OP_REQUEST) add_result(KIND_REPLY, it.sender_ip, it.sender_mac);
            end
         end
         REQ_QUERY: begin
            slot = cache_slot(it.target_ip);
            if (slot >= 0) begin
               add_result(KIND_HIT, it.target_ip, cache_mac[slot]);
            end else begin
               free_slot = -1;
               waiting   = 1'b0;
               for (int i = 0; i < PENDING_ENTRIES; i++) begin
                  if (pend_used[i] && pend_ip[i] == it.target_ip) waiting = 1'b1;
                  else if (!pend_used[i] && free_slot < 0) free_slot = i;
               end
               if (waiting) begin
                  add_result(KIND_QUEUED, it.target_ip, '0);
               end else if (free_slot >= 0) begin
                  pend_used[free_slot] = 1'b1;
                  pend_ip[free_slot]   = it.target_ip;
                  pend_try[free_slot]  = '0;
                  pend_left[free_slot] = retry_ticks('0);
                  add_result(KIND_BCAST, it.target_ip, '0);
               end else begin
                  add_result(KIND_DROPPED, it.target_ip, '0);
               end
            end
         end
         REQ_TICK: begin
            for (int i = 0; i < PENDING_ENTRIES; i++) begin
               if (pend_used[i]) begin
                  if (pend_left[i] > 1) begin
                     pend_left[i] = pend_left[i] - 1'b1;
                  end else begin
                     slot = cache_slot(pend_ip[i]);
                     if (slot >= 0) begin
                        add_result(KIND_RESOLVED, pend_ip[i], cache_mac[slot]);
                        pend_used[i] = 1'b0;
                     end else if (pend_try[i] >= TRIES_MAX) begin
                        add_result(KIND_GAVEUP, pend_ip[i], '0);
                        pend_used[i] = 1'b0;
                     end else begin
                        pend_try[i]  = pend_try[i] + 1'b1;
                        pend_left[i] = retry_ticks(pend_try[i]);
                        add_result(KIND_BCAST, pend_ip[i], '0);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) arp_results_due.push_back(step_results[i]);
   endfunction

   function automatic logic [IP_W-1:0] pool_addr(input int k);
      return 32'h0A00_0000 + IP_W'(k);
   endfunction

   function automatic logic [OP_W-1:0] pick_opcode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return ARP_OP_REQUEST;
      if (roll < 85) return ARP_OP_REPLY;
      return OP_W'($urandom);
   endfunction

   function automatic arpc_item_type arp_item(input logic [TYPE_W-1:0] kind,
                                              input logic [OP_W-1:0] op,
                                              input logic [IP_W-1:0] sip,
                                              input logic [MAC_W-1:0] smac,
                                              input logic [IP_W-1:0] tip);
      arpc_item_type it;
      it.req_type   = kind;
      it.opcode     = op;
      it.sender_ip  = sip;
      it.sender_mac = smac;
      it.target_ip  = tip;
      return it;
   endfunction

   function automatic arpc_item_type random_request(input traffic_type mix);
      arpc_item_type it;
      int roll;
      int learn_cut;
      int foreign_cut;
      int query_cut;
      int tick_cut;
      it   = arp_item(REQ_PACKET, OP_W'($urandom), $urandom, MAC_W'({$urandom, $urandom}),
                      $urandom);
      roll = $urandom_range(0, 99);
      if (mix == TRAFFIC_FILL && roll < 98) begin
         it.target_ip = cfg_ip;
         it.sender_ip = 32'h0B00_0000 + IP_W'(fill_serial);
         it.opcode    = pick_opcode();
         fill_serial++;
         return it;
      end
      roll = $urandom_range(0, 99);
      if (mix == TRAFFIC_TICKS) begin
         learn_cut = 20; foreign_cut = 25; query_cut = 50; tick_cut = 98;
      end else begin
         learn_cut = 30; foreign_cut = 38; query_cut = 70; tick_cut = 97;
      end
      if (roll < learn_cut) begin
         it.target_ip = cfg_ip;
         it.sender_ip = pool_addr($urandom_range(0, POOL_SIZE - 1));
         it.opcode    = pick_opcode();
      end else if (roll < foreign_cut) begin
         it.req_type = REQ_PACKET;
      end else if (roll < query_cut) begin
         it.req_type = REQ_QUERY;
         if ($urandom_range(0, 99) < 85) it.target_ip = pool_addr($urandom_range(0, POOL_SIZE - 1));
      end else if (roll < tick_cut) begin
         it.req_type = REQ_TICK;
      end else begin
         it.req_type = REQ_UNUSED;
      end
      return it;
   endfunction

   function automatic void queue_request(input arpc_item_type it, input bit hold);
      pending_request_type p;
      p.item = it;
      p.gap  = draw_wait();
      p.hold = hold;
      requests_to_send.push_back(p);
      requests_issued++;
   endfunction

   function automatic void queue_traffic(input traffic_type mix, input int count);
      for (int i = 0; i < count; i++)
         queue_request(random_request(mix), $urandom_range(0, 99) < 3);
   endfunction

   task automatic configure(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                            input logic [BASE_W-1:0] base);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LOCAL_IP;
      csr_wdata <= CSR_W'(ip);
      @(posedge clock);
      csr_index <= CSR_LOCAL_MAC;
      csr_wdata <= mac;
      @(posedge clock);
      csr_index <= CSR_BASE_INTERVAL;
      csr_wdata <= CSR_W'(base);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_ip   = ip;
      cfg_mac  = mac;
      cfg_base = base;
   endtask

   task automatic settle();
      do @(posedge clock);
      while (requests_accepted != requests_issued || arp_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            arp_engine_predict(in_flight.item);
            requests_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (requests_to_send.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (requests_to_send[0].gap > 0) begin
               requests_to_send[0].gap = requests_to_send[0].gap - 1;
               req_ch.valid <= 1'b0;
            end else if (requests_to_send[0].hold && arp_results_due.size() != 0) begin
               req_ch.valid <= 1'b0;
            end else begin
               in_flight = requests_to_send.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.req_type   <= in_flight.item.req_type;
               req_ch.opcode     <= in_flight.item.opcode;
               req_ch.sender_ip  <= in_flight.item.sender_ip;
               req_ch.sender_mac <= in_flight.item.sender_mac;
               req_ch.target_ip  <= in_flight.item.target_ip;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         observed.kind = rsp_ch.out_kind;
         observed.ip   = rsp_ch.out_ip;
         observed.mac  = rsp_ch.out_mac;
         observed.last = rsp_ch.last;
         kind_tally[observed.kind]++;
         results_checked++;
         if (arp_results_due.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: kind %0d ip %h mac %h last %b",
                        observed.kind, observed.ip, observed.mac, observed.last);
            error_count++;
         end else begin
            wanted = arp_results_due.pop_front();
            if (wanted.kind !== observed.kind || wanted.ip !== observed.ip ||
                wanted.mac !== observed.mac || wanted.last !== observed.last) begin
               if (error_count < 10)
                  $display("result %0d: expected kind %0d ip %h mac %h last %b, got kind %0d ip %h mac %h last %b",
                           results_checked, wanted.kind, wanted.ip, wanted.mac, wanted.last,
                           observed.kind, observed.ip, observed.mac, observed.last);
               error_count++;
            end
         end
         rsp_draw = draw_wait();
         rsp_wait     <= rsp_draw;
         rsp_ch.ready <= (rsp_draw == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait     <= rsp_wait - 1;
         rsp_ch.ready <= (rsp_wait == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = '0;
      req_ch.opcode     = '0;
      req_ch.sender_ip  = '0;
      req_ch.sender_mac = '0;
      req_ch.target_ip  = '0;
      rsp_ch.ready      = 1'b0;
      cfg_ip            = '0;
      cfg_mac           = '0;
      cfg_base          = BASE_INTERVAL_RESET;
      foreach (cache_used[i]) cache_used[i] = 1'b0;
      foreach (pend_used[i]) pend_used[i] = 1'b0;
      foreach (kind_tally[i]) kind_tally[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      configure(32'hC0A8_0101, '1, 16'd1);
      queue_request(arp_item(REQ_PACKET, ARP_OP_REQUEST, 32'h0A0A_0A0A, '1, 32'hC0A8_0102), 0);
      queue_request(arp_item(REQ_PACKET, ARP_OP_REQUEST, '1, '1, cfg_ip), 0);
      queue_request(arp_item(REQ_PACKET, ARP_OP_REPLY, '0, '0, cfg_ip), 0);
      queue_request(arp_item(REQ_PACKET, '1, pool_addr(1), 48'h5A5A_A5A5_5A5A, cfg_ip), 0);
      queue_request(arp_item(REQ_PACKET, ARP_OP_REQUEST, '1, 48'h0123_4567_89AB, cfg_ip), 0);
      queue_request(arp_item(REQ_QUERY, '0, '0, '0, '1), 0);
      queue_request(arp_item(REQ_QUERY, '1, '1, '1, '0), 0);
      queue_request(arp_item(REQ_QUERY, '0, '0, '0, pool_addr(20)), 0);
      queue_request(arp_item(REQ_QUERY, '0, '0, '0, pool_addr(20)), 0);
      for (int k = 21; k <= 27; k++)
         queue_request(arp_item(REQ_QUERY, '0, '0, '0, pool_addr(k)), 0);
      queue_request(arp_item(REQ_QUERY, '0, '0, '0, pool_addr(28)), 0);
      queue_request(arp_item(REQ_UNUSED, '1, '1, '1, cfg_ip), 0);
      queue_request(arp_item(REQ_TICK, '0, '0, '0, '0), 1);
      queue_request(arp_item(REQ_PACKET, ARP_OP_REPLY, pool_addr(20), 48'hBEEF_0000_0020, cfg_ip), 0);
      queue_request(arp_item(REQ_TICK, '1, '1, '1, '1), 0);
      queue_request(arp_item(REQ_TICK, '0, '0, '0, '0), 0);
      queue_request(arp_item(REQ_PACKET, 16'd0, pool_addr(29), 48'h8000_0000_0001, cfg_ip), 0);
      settle();

      configure(32'hC0A8_0101, 48'h0000_1111_2222, 16'd1);
      queue_traffic(TRAFFIC_TICKS, 50);
      settle();

      calm = 1'b1;
      configure('1, '0, 16'd0);
      queue_traffic(TRAFFIC_MIXED, 50);
      settle();
      calm = 1'b0;

      configure('0, MAC_W'({$urandom, $urandom}), 16'd3);
      queue_traffic(TRAFFIC_MIXED, 50);
      settle();

      configure($urandom, MAC_W'({$urandom, $urandom}), 16'd2);
      queue_traffic(TRAFFIC_FILL, 265);
      settle();

      configure(cfg_ip, MAC_W'({$urandom, $urandom}), 16'hFFFF);
      queue_traffic(TRAFFIC_MIXED, 30);
      settle();

      $display("covered %0d requests and %0d results: %0d replies, %0d broadcasts, %0d hits,",
               requests_accepted, results_checked, kind_tally[KIND_REPLY],
               kind_tally[KIND_BCAST], kind_tally[KIND_HIT]);
      $display("  %0d queued, %0d resolved, %0d gave up, %0d dropped; %0d errors",
               kind_tally[KIND_QUEUED], kind_tally[KIND_RESOLVED], kind_tally[KIND_GAVEUP],
               kind_tally[KIND_DROPPED], error_count);
      if (error_count == 0 && arp_results_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/arpc_pkg.sv
src/arpc_req_if.sv
src/arpc_rsp_if.sv
src/arpc_cache.sv
src/arpc_seq.sv
src/arp_cache_responder_resolver_unit.sv
src/arpc_checker.sv
dv/arp_cache_responder_resolver_unit_tb.sv
